[rtl/core/ppv_pkg.sv]
package ppv_pkg;

    localparam int MAX_PATH_LEN_DEF = 2048;
    localparam int MAX_COMP_LEN_DEF = 255;

    localparam int BASE_DEPTH = 6;
    localparam int TAIL_DEPTH = 17;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_PATH     = 3'd1;
    localparam logic [2:0] ERR_COMP     = 3'd2;
    localparam logic [2:0] ERR_TRAIL    = 3'd3;
    localparam logic [2:0] ERR_TILDE    = 3'd4;
    localparam logic [2:0] ERR_RESERVED = 3'd5;
    localparam logic [2:0] ERR_CHAR     = 3'd6;
    localparam logic [2:0] ERR_TERRAIN  = 3'd7;

    localparam logic [7:0] CHAR_MIN = 8'h21;
    localparam logic [7:0] CHAR_MAX = 8'h7e;

    localparam logic [8*16-1:0] PFX_DERIVED   = "derived/terrain/";
    localparam logic [8*16-1:0] PFX_STAGING   = "staging/terrain/";
    localparam logic [8*27-1:0] PFX_SOURCE    = "sourceobservations/terrain/";
    localparam logic [8*17-1:0] SFX_HEIGHTMAP = ".tgheightmap.json";
    localparam logic [8*14-1:0] SFX_TILE      = ".terrain.u16le";
    localparam logic [8*4-1:0]  SFX_GSI       = "_gsi";

    localparam logic [8*6-1:0] NAME_CLOCK = "clock$";
    localparam logic [8*3-1:0] NAME_CON   = "con";
    localparam logic [8*3-1:0] NAME_PRN   = "prn";
    localparam logic [8*3-1:0] NAME_AUX   = "aux";
    localparam logic [8*3-1:0] NAME_NUL   = "nul";
    localparam logic [8*3-1:0] NAME_COM   = "com";
    localparam logic [8*3-1:0] NAME_LPT   = "lpt";

    // per-component tracking, base name shifted in newest byte lowest
    typedef struct packed {
        logic                      dots_only;
        logic [7:0]                prev_byte;
        logic                      tilde;
        logic                      bad_byte;
        logic [8*BASE_DEPTH-1:0]   base_bytes;
        logic [2:0]                base_len;
        logic                      base_closed;
    } comp_t;

    localparam comp_t COMP_CLEAR = '{
        dots_only:   1'b1,
        prev_byte:   8'd0,
        tilde:       1'b0,
        bad_byte:    1'b0,
        base_bytes:  '0,
        base_len:    3'd0,
        base_closed: 1'b0
    };

    function automatic logic [7:0] derived_char(input logic [3:0] idx);
        return PFX_DERIVED[8*(15-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] staging_char(input logic [3:0] idx);
        return PFX_STAGING[8*(15-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] source_char(input logic [4:0] idx);
        logic [7:0] c;
        c = 8'd0;
        if (int'(idx) < 27) begin
            c = PFX_SOURCE[8*(26-int'(idx)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function automatic logic is_bad_char(input logic [7:0] b);
        return b < CHAR_MIN || b > CHAR_MAX || b == "\\" || b == ":" || b == "\"" ||
               b == "<" || b == ">" || b == "|" || b == "?" || b == "*";
    endfunction

    function automatic logic base_reserved(input comp_t c);
        logic r;
        r = 1'b0;
        if (c.base_len == 3'd3) begin
            r = c.base_bytes[23:0] == NAME_CON || c.base_bytes[23:0] == NAME_PRN ||
                c.base_bytes[23:0] == NAME_AUX || c.base_bytes[23:0] == NAME_NUL;
        end
        if (c.base_len == 3'd6 && c.base_bytes == NAME_CLOCK) begin
            r = 1'b1;
        end
        if (c.base_len == 3'd4 && c.base_bytes[7:0] >= "1" && c.base_bytes[7:0] <= "9" &&
            (c.base_bytes[31:8] == NAME_COM || c.base_bytes[31:8] == NAME_LPT)) begin
            r = 1'b1;
        end
        return r;
    endfunction

endpackage

[rtl/core/package_path_validator_unit.sv]
// Channel   Ports                                            Direction
// s_        s_valid s_ready s_path_byte s_final_byte         request in
// m_        m_valid m_ready m_ident_byte m_verdict_ready
//           m_path_ok m_error_code m_terrain_match           result out
// cfg_      cfg_valid cfg_ready cfg_reject_terrain           register write
//
// One request per cycle while the result is not stalled, through an input register then the result register.
// The input register refills in the cycle its request moves to the result register.
// Synchronous active-low reset clears both valid flags and all path tracking.
// A stalled result holds the input register; s_ready drops only when both are full.
// All path tracking returns to its reset value after every final byte.
module package_path_validator_unit #(
    parameter int MAX_PATH_LEN = ppv_pkg::MAX_PATH_LEN_DEF,
    parameter int MAX_COMP_LEN = ppv_pkg::MAX_COMP_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_path_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_ident_byte,
    output logic       m_verdict_ready,
    output logic       m_path_ok,
    output logic [2:0] m_error_code,
    output logic       m_terrain_match,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_reject_terrain
);
    import ppv_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATH_LEN + 2);
    localparam int LEN_W = $clog2(MAX_COMP_LEN + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_PATH_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_COMP_LEN + 1);

    logic                    reject_reg;

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_final_reg;

    logic                    out_valid_reg;
    logic [7:0]              out_ident_reg,   out_ident_next;
    logic                    out_verdict_reg;
    logic                    out_ok_reg,      out_ok_next;
    logic [2:0]              out_code_reg,    out_code_next;
    logic                    out_terrain_reg, out_terrain_next;

    logic [CNT_W-1:0]        cnt_reg,         cnt_next;
    logic                    start_bad_reg,   start_bad_next;
    logic [2:0]              fce_reg,         fce_next;
    logic [LEN_W-1:0]        len_reg,         len_next;
    comp_t                   comp_reg,        comp_next;
    logic [2:0]              alive_reg,       alive_next;
    logic [8*TAIL_DEPTH-1:0] tail_reg,        tail_next;
    logic                    gsi_reg,         gsi_next;

    logic                    advance;
    logic [7:0]              b;
    logic [7:0]              lb;
    comp_t                   comp_upd;
    logic [LEN_W-1:0]        len_upd;
    comp_t                   comp_a;
    logic [LEN_W-1:0]        len_a;
    logic [2:0]              fce_a;
    logic [2:0]              fce_b;
    logic [2:0]              err;
    logic                    terr;

    function automatic logic [2:0] comp_err(input comp_t c, input logic [LEN_W-1:0] n);
        logic [2:0] e;
        e = ERR_NONE;
        if (n == '0 || (c.dots_only && n <= LEN_W'(2)) || n == LEN_SAT) begin
            e = ERR_COMP;
        end else if (c.prev_byte == "." || c.prev_byte == " ") begin
            e = ERR_TRAIL;
        end else if (c.tilde) begin
            e = ERR_TILDE;
        end else if (base_reserved(c)) begin
            e = ERR_RESERVED;
        end else if (c.bad_byte) begin
            e = ERR_CHAR;
        end
        return e;
    endfunction

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid         = out_valid_reg;
    assign m_ident_byte    = out_ident_reg;
    assign m_verdict_ready = out_verdict_reg;
    assign m_path_ok       = out_ok_reg;
    assign m_error_code    = out_code_reg;
    assign m_terrain_match = out_terrain_reg;

    always_comb begin
        b  = in_byte_reg;
        lb = to_lower(b);

        start_bad_next = start_bad_reg ||
                         (cnt_reg == '0 && (b == "/" || b == "\\")) ||
                         (cnt_reg == CNT_W'(1) && b == ":");

        alive_next = alive_reg;
        if (cnt_reg < CNT_W'(16) && lb != derived_char(cnt_reg[3:0])) begin
            alive_next[0] = 1'b0;
        end
        if (cnt_reg < CNT_W'(16) && lb != staging_char(cnt_reg[3:0])) begin
            alive_next[1] = 1'b0;
        end
        if (cnt_reg < CNT_W'(27) && lb != source_char(cnt_reg[4:0])) begin
            alive_next[2] = 1'b0;
        end

        cnt_next  = (cnt_reg < CNT_SAT) ? cnt_reg + CNT_W'(1) : cnt_reg;
        tail_next = {tail_reg[8*(TAIL_DEPTH-1)-1:0], lb};
        gsi_next  = gsi_reg || tail_next[31:0] == SFX_GSI;

        comp_upd = comp_reg;
        len_upd  = (len_reg < LEN_SAT) ? len_reg + LEN_W'(1) : len_reg;
        if (b != ".") begin
            comp_upd.dots_only = 1'b0;
        end
        comp_upd.prev_byte = b;
        if (b == "~") begin
            comp_upd.tilde = 1'b1;
        end
        if (is_bad_char(b)) begin
            comp_upd.bad_byte = 1'b1;
        end
        if (!comp_reg.base_closed) begin
            if (b == ".") begin
                comp_upd.base_closed = 1'b1;
            end else if (comp_reg.base_len < 3'(BASE_DEPTH)) begin
                comp_upd.base_bytes = {comp_reg.base_bytes[8*(BASE_DEPTH-1)-1:0], lb};
                comp_upd.base_len   = comp_reg.base_len + 3'd1;
            end else begin
                comp_upd.base_len = 3'd7;
            end
        end

        if (b == "/") begin
            comp_a = COMP_CLEAR;
            len_a  = '0;
            fce_a  = (fce_reg == ERR_NONE) ? comp_err(comp_reg, len_reg) : fce_reg;
        end else begin
            comp_a = comp_upd;
            len_a  = len_upd;
            fce_a  = fce_reg;
        end

        fce_b = (fce_a == ERR_NONE) ? comp_err(comp_a, len_a) : fce_a;
        err   = (start_bad_next || cnt_next == CNT_SAT) ? ERR_PATH : fce_b;
        terr  = 1'b0;
        if (err == ERR_NONE) begin
            terr = ((alive_next[0] || alive_next[1]) && cnt_next >= CNT_W'(16)) ||
                   (alive_next[2] && cnt_next >= CNT_W'(27)) ||
                   tail_next == SFX_HEIGHTMAP ||
                   tail_next[8*14-1:0] == SFX_TILE || gsi_next;
            if (terr && reject_reg) begin
                err = ERR_TERRAIN;
            end
        end

        out_ident_next   = lb;
        out_ok_next      = in_final_reg && err == ERR_NONE;
        out_code_next    = in_final_reg ? err : ERR_NONE;
        out_terrain_next = in_final_reg && terr;

        comp_next = comp_a;
        len_next  = len_a;
        fce_next  = fce_a;
        if (in_final_reg) begin
            cnt_next       = '0;
            start_bad_next = 1'b0;
            fce_next       = ERR_NONE;
            len_next       = '0;
            comp_next      = COMP_CLEAR;
            alive_next     = 3'b111;
            tail_next      = '0;
            gsi_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reject_reg    <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            start_bad_reg <= 1'b0;
            fce_reg       <= ERR_NONE;
            len_reg       <= '0;
            comp_reg      <= COMP_CLEAR;
            alive_reg     <= 3'b111;
            tail_reg      <= '0;
            gsi_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                reject_reg <= cfg_reject_terrain;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_path_byte;
                in_final_reg <= s_final_byte;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                out_ident_reg   <= out_ident_next;
                out_verdict_reg <= in_final_reg;
                out_ok_reg      <= out_ok_next;
                out_code_reg    <= out_code_next;
                out_terrain_reg <= out_terrain_next;
                cnt_reg         <= cnt_next;
                start_bad_reg   <= start_bad_next;
                fce_reg         <= fce_next;
                len_reg         <= len_next;
                comp_reg        <= comp_next;
                alive_reg       <= alive_next;
                tail_reg        <= tail_next;
                gsi_reg         <= gsi_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[bench/package_path_validator_unit_tb.sv]
module package_path_validator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppv_pkg::*;

    localparam int PATH_LIMIT     = 2048;
    localparam int COMP_LIMIT     = 255;
    localparam int RANDOM_BYTES   = 1150;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int TAIL_LEN       = 17;

    localparam logic [7:0] SLASH     = "/";
    localparam logic [7:0] BACKSLASH = "\\";
    localparam logic [7:0] COLON     = ":";
    localparam logic [7:0] DOT       = ".";
    localparam logic [7:0] SPACE     = " ";
    localparam logic [7:0] TILDE     = "~";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } path_req_t;

    typedef struct packed {
        logic [7:0] ident;
        logic       verdict;
        logic       ok;
        logic [2:0] code;
        logic       terrain;
    } ident_t;

    string derived_root = "derived/terrain/";
    string staging_root = "staging/terrain/";
    string source_root  = "sourceobservations/terrain/";
    string word_chars   =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.";
    string forbidden    = "\\:\"<>|?* ";

    logic       aclk               = 1'b0;
    logic       aresetn            = 1'b0;
    logic       s_valid            = 1'b0;
    logic       s_ready;
    logic [7:0] s_path_byte        = 8'd0;
    logic       s_final_byte       = 1'b0;
    logic       m_valid;
    logic       m_ready            = 1'b0;
    logic [7:0] m_ident_byte;
    logic       m_verdict_ready;
    logic       m_path_ok;
    logic [2:0] m_error_code;
    logic       m_terrain_match;
    logic       cfg_valid          = 1'b0;
    logic       cfg_ready;
    logic       cfg_reject_terrain = 1'b0;

    package_path_validator_unit i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_path_byte       (s_path_byte),
        .s_final_byte      (s_final_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ident_byte      (m_ident_byte),
        .m_verdict_ready   (m_verdict_ready),
        .m_path_ok         (m_path_ok),
        .m_error_code      (m_error_code),
        .m_terrain_match   (m_terrain_match),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_reject_terrain(cfg_reject_terrain)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    path_req_t  path_byte_q[$];
    ident_t     ident_q[$];
    logic [7:0] path_buf[$];

    int  failures       = 0;
    int  cycles         = 0;
    int  send_wait      = 0;
    int  recv_wait      = 0;
    int  hold_left      = 0;
    int  holdoff_asked  = 0;
    int  holdoff_served = 0;
    bit  no_idle        = 1'b0;
    int  bytes_checked  = 0;
    int  paths_checked  = 0;
    int  terrain_seen   = 0;
    int  cfg_writes     = 0;
    int  code_seen[8];

    // path tracking
    bit         reject_q;
    logic [11:0] byte_cnt;
    bit          lead_bad;
    logic [2:0]  first_err;
    logic [8:0]  seg_len;
    bit          seg_dots;
    logic [7:0]  seg_last;
    bit          seg_tilde;
    bit          seg_badc;
    logic [7:0]  stem[6];
    logic [2:0]  stem_len;
    bit          stem_done;
    logic [2:0]  prefix_live;
    logic [7:0]  tail[TAIL_LEN];
    bit          gsi_hit;

    function automatic void clear_segment();
        seg_len   = '0;
        seg_dots  = 1'b1;
        seg_last  = '0;
        seg_tilde = 1'b0;
        seg_badc  = 1'b0;
        foreach (stem[i]) stem[i] = '0;
        stem_len  = '0;
        stem_done = 1'b0;
    endfunction

    function automatic void clear_path();
        byte_cnt    = '0;
        lead_bad    = 1'b0;
        first_err   = ERR_NONE;
        prefix_live = 3'b111;
        foreach (tail[i]) tail[i] = '0;
        gsi_hit     = 1'b0;
        clear_segment();
    endfunction

    function automatic bit stem_is(string name);
        if (stem_len != name.len()) return 1'b0;
        for (int i = 0; i < name.len(); i++) begin
            if (stem[i] != name[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit stem_reserved();
        if (stem_is("con") || stem_is("prn") || stem_is("aux") || stem_is("nul") ||
            stem_is("clock$")) begin
            return 1'b1;
        end
        return stem_len == 3'd4 && stem[3] >= "1" && stem[3] <= "9" &&
               ({stem[0], stem[1], stem[2]} == "com" || {stem[0], stem[1], stem[2]} == "lpt");
    endfunction

    function automatic bit tail_has(string s);
        for (int i = 0; i < s.len(); i++) begin
            if (tail[TAIL_LEN - s.len() + i] != s[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // judge the segment just closed, keep only the first failure
    function automatic void close_segment();
        logic [2:0] e;
        e = ERR_NONE;
        if (seg_len == 0 || (seg_dots && seg_len <= 2) || seg_len > COMP_LIMIT) begin
            e = ERR_COMP;
        end else if (seg_last == DOT || seg_last == SPACE) begin
            e = ERR_TRAIL;
        end else if (seg_tilde) begin
            e = ERR_TILDE;
        end else if (stem_reserved()) begin
            e = ERR_RESERVED;
        end else if (seg_badc) begin
            e = ERR_CHAR;
        end
        if (first_err == ERR_NONE) first_err = e;
        clear_segment();
    endfunction

    function automatic ident_t lower_and_judge(logic [7:0] b, logic fin);
        logic [7:0] lb;
        int         pos;
        ident_t     r;
        lb = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        pos = byte_cnt;
        r = '0;
        r.ident = lb;
        r.verdict = fin;
        if (pos == 0 && (b == SLASH || b == BACKSLASH)) lead_bad = 1'b1;
        if (pos == 1 && b == COLON) lead_bad = 1'b1;
        if (prefix_live[0] && pos < 16 && lb != derived_root[pos]) prefix_live[0] = 1'b0;
        if (prefix_live[1] && pos < 16 && lb != staging_root[pos]) prefix_live[1] = 1'b0;
        if (prefix_live[2] && pos < 27 && lb != source_root[pos]) prefix_live[2] = 1'b0;
        if (byte_cnt < PATH_LIMIT + 1) byte_cnt++;
        for (int i = 0; i < TAIL_LEN - 1; i++) tail[i] = tail[i + 1];
        tail[TAIL_LEN - 1] = lb;
        if (tail_has("_gsi")) gsi_hit = 1'b1;
        if (b == SLASH) begin
            close_segment();
        end else begin
            if (seg_len < COMP_LIMIT + 1) seg_len++;
            if (b != DOT) seg_dots = 1'b0;
            seg_last = b;
            if (b == TILDE) seg_tilde = 1'b1;
            if (b < 8'h21 || b > 8'h7e || b == BACKSLASH || b == COLON || b == "\"" ||
                b == "<" || b == ">" || b == "|" || b == "?" || b == "*") begin
                seg_badc = 1'b1;
            end
            if (!stem_done) begin
                if (b == DOT) begin
                    stem_done = 1'b1;
                end else if (stem_len < 6) begin
                    stem[stem_len] = lb;
                    stem_len++;
                end else begin
                    stem_len = 3'd7;
                end
            end
        end
        if (fin) begin
            close_segment();
            r.code = (lead_bad || byte_cnt > PATH_LIMIT) ? ERR_PATH : first_err;
            if (r.code == ERR_NONE) begin
                r.terrain = (prefix_live[0] && byte_cnt >= 16) ||
                            (prefix_live[1] && byte_cnt >= 16) ||
                            (prefix_live[2] && byte_cnt >= 27) ||
                            tail_has(".tgheightmap.json") || tail_has(".terrain.u16le") ||
                            gsi_hit;
                if (r.terrain && reject_q) r.code = ERR_TERRAIN;
            end
            r.ok = r.code == ERR_NONE;
            clear_path();
        end
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge aclk) begin : driver
        path_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                ident_q.insert(ident_q.size(), lower_and_judge(s_path_byte, s_final_byte));
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (path_byte_q.size() != 0) begin
                    req = path_byte_q.pop_front();
                    s_path_byte  <= req.data;
                    s_final_byte <= req.last;
                    s_valid      <= 1'b1;
                    send_wait = idle_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        ident_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (ident_q.size() == 0) begin
                    $display("%0t: unrequested result, expected none actual ident %0h",
                             $time, m_ident_byte);
                    failures++;
                end else begin
                    want = ident_q.pop_front();
                    check_field("ident_byte", want.ident, m_ident_byte);
                    check_field("verdict_ready", want.verdict, m_verdict_ready);
                    check_field("path_ok", want.ok, m_path_ok);
                    check_field("error_code", want.code, m_error_code);
                    check_field("terrain_match", want.terrain, m_terrain_match);
                    bytes_checked++;
                    if (want.verdict) begin
                        paths_checked++;
                        code_seen[want.code]++;
                        if (want.terrain) terrain_seen++;
                    end
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_wait = idle_gap();
            end
        end
    end

    // hold the result side off while requests keep coming
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holdoff_served != holdoff_asked) begin
            hold_left      <= HOLDOFF_CYCLES;
            holdoff_served <= holdoff_asked;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[package_path_validator_unit] ERROR");
            $finish;
        end
    end

    task automatic add_byte(logic [7:0] c);
        path_buf.insert(path_buf.size(), c);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic send_path();
        path_req_t r;
        foreach (path_buf[i]) begin
            r.data = path_buf[i];
            r.last = (i == path_buf.size() - 1);
            path_byte_q.insert(path_byte_q.size(), r);
        end
        path_buf.delete();
    endtask

    task automatic send_text(string s);
        put_text(s);
        send_path();
    endtask

    task automatic send_filler(int total, int span);
        for (int i = 0; i < total; i++) begin
            add_byte(((i + 1) % (span + 1) == 0) ? SLASH : 8'(8'h61 + i % 26));
        end
        send_path();
    endtask

    task automatic put_word();
        int n;
        n = $urandom_range(1, 9);
        repeat (n) add_byte(word_chars[$urandom_range(0, word_chars.len() - 1)]);
    endtask

    task automatic put_reserved();
        case ($urandom_range(0, 6))
            0: put_text("con");
            1: put_text("PRN");
            2: put_text("aux");
            3: put_text("Nul");
            4: put_text("clock$");
            5: begin
                put_text("CoM");
                add_byte(8'($urandom_range(48, 57)));
            end
            default: begin
                put_text("lpt");
                add_byte(8'($urandom_range(48, 57)));
            end
        endcase
    endtask

    task automatic put_segment();
        case ($urandom_range(0, 19))
            12: put_text(".");
            13: put_text("..");
            14: put_reserved();
            15: begin
                put_reserved();
                put_text(".txt");
            end
            16: begin
                put_word();
                add_byte(TILDE);
                put_word();
            end
            17: begin
                put_word();
                if ($urandom_range(0, 1)) begin
                    add_byte(forbidden[$urandom_range(0, forbidden.len() - 1)]);
                end else begin
                    add_byte(8'($urandom_range(0, 255)));
                end
                put_word();
            end
            18: begin
                put_word();
                add_byte($urandom_range(0, 1) ? DOT : SPACE);
            end
            19: put_text($urandom_range(0, 1) ? "console" : "Clock$x.y");
            default: put_word();
        endcase
    endtask

    task automatic build_random_path();
        int shape;
        int parts;
        int k;
        shape = $urandom_range(0, 99);
        if (shape < 20) begin
            parts = $urandom_range(1, 12);
            repeat (parts) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        if (shape < 45) begin
            case ($urandom_range(0, 3))
                0: put_text("derived/terrain/");
                1: put_text("Staging/Terrain/");
                2: put_text("sourceobservations/terrain/");
                default: put_text("SourceObservations/terrain");
            endcase
        end
        parts = $urandom_range(1, 4);
        for (int p = 0; p < parts; p++) begin
            if (p > 0) add_byte(SLASH);
            put_segment();
        end
        case ($urandom_range(0, 9))
            0: put_text(".tgheightmap.json");
            1: put_text(".TERRAIN.u16le");
            2: put_text("_gsi");
            3: put_text("_GSI");
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, path_buf.size() - 1);
            case ($urandom_range(0, 5))
                0: path_buf.push_front(SLASH);
                1: path_buf.push_front(BACKSLASH);
                2: if (path_buf.size() > 1) path_buf[1] = COLON;
                3: add_byte(SLASH);
                4: path_buf.insert(k, SLASH);
                default: path_buf[k] = 8'($urandom_range(0, 255));
            endcase
        end
    endtask

    task automatic send_random(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            build_random_path();
            sent += path_buf.size();
            send_path();
        end
    endtask

    task automatic send_terrain_set();
        send_text("derived/terrain/x");
        send_text("Staging/Terrain/y");
        send_text("sourceobservations/terrain/z");
        send_text("t.terrain.u16le");
        send_text("h.TGHEIGHTMAP.json");
        send_text("x_gsi/b");
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (path_byte_q.size() != 0 || s_valid || ident_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reject(bit v);
        @(posedge aclk);
        cfg_valid          <= 1'b1;
        cfg_reject_terrain <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reject_q = v;
        cfg_writes++;
    endtask

    initial begin
        reject_q = 1'b0;
        clear_path();
        foreach (code_seen[i]) code_seen[i] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        write_reject(1'b0);
        send_text("a");
        send_text("/a~");
        send_text("\\a");
        send_text("c:x");
        send_text("a//b");
        send_text("a/");
        send_text("./..");
        send_text("a.");
        send_text("a ");
        send_text("a~/con");
        send_text("COM3.txt");
        send_text("lpt9/com0/console/clock$");
        send_text("a<b");
        add_byte(8'h00);
        send_path();
        add_byte(8'hff);
        send_path();
        send_terrain_set();
        wait_drained();

        write_reject(1'b1);
        send_terrain_set();
        send_random(RANDOM_BYTES * 3 / 8);
        holdoff_asked = 1;
        wait_drained();

        write_reject(1'b0);
        no_idle = 1'b1;
        send_filler(COMP_LIMIT, COMP_LIMIT);
        send_filler(COMP_LIMIT + 1, COMP_LIMIT + 1);
        send_filler(PATH_LIMIT, 200);
        send_filler(PATH_LIMIT + 1, 200);
        send_random(RANDOM_BYTES / 4);
        wait_drained();
        no_idle = 1'b0;

        write_reject(1'b1);
        send_random(RANDOM_BYTES * 3 / 8);
        wait_drained();
        repeat (8) @(posedge aclk);

        $display("checked %0d bytes in %0d paths over %0d register writes, %0d terrain hits",
                 bytes_checked, paths_checked, cfg_writes, terrain_seen);
        $display({"verdicts ok/path/comp/trail/tilde/reserved/char/terrain: ",
                  "%0d %0d %0d %0d %0d %0d %0d %0d"},
                 code_seen[0], code_seen[1], code_seen[2], code_seen[3],
                 code_seen[4], code_seen[5], code_seen[6], code_seen[7]);
        if (failures == 0) begin
            $display("[package_path_validator_unit] OK");
        end else begin
            $display("[package_path_validator_unit] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ppv_pkg.sv
rtl/core/package_path_validator_unit.sv
bench/package_path_validator_unit_tb.sv
